// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/imufp_pkg.sv
`default_nettype none
package imufp_pkg;

	localparam int FRAME_BYTES_DEF = 18;
	localparam logic [7:0] HEADER_BYTE = 8'h5A;
	localparam logic [15:0] WRAP_THRESHOLD_RST = 16'd30000;
	localparam logic signed [31:0] TURN_HUNDREDTHS = 32'sd36000;
	localparam logic signed [15:0] TURN_MAX = 16'sh7FFF;
	localparam logic signed [15:0] TURN_MIN = 16'sh8000;
	localparam int OUT_BITS = 184;

	// Fields lifted straight out of a matched frame.
	typedef struct packed {
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic [15:0]        yaw_angle;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic [7:0]         device_status;
	} imufp_frame_t;

	// Yaw tracking state after the current frame is applied.
	typedef struct packed {
		logic signed [15:0] turns;
		logic signed [31:0] total_yaw;
		logic [31:0]        frame_number;
	} imufp_track_t;

endpackage
`default_nettype wire

// File: rtl/imufp_window.sv
`default_nettype none
module imufp_window
	import imufp_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         step,
	output imufp_frame_t      frame,
	output logic              hit
);
	localparam int FILL_W = $clog2(FRAME_BYTES + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);

	logic [7:0] win_q [FRAME_BYTES];
	logic [7:0] win_nx [FRAME_BYTES];
	logic [7:0] sum_q;
	logic [7:0] sum_nx;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_nx;

	// sum_q tracks the 8-bit sum of every byte but the last one in the window.
	always_comb begin
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			win_nx[i] = win_q[i+1];
		end
		win_nx[FRAME_BYTES-1] = rx_byte;
		sum_nx  = sum_q - win_q[0] + win_q[FRAME_BYTES-1];
		fill_nx = (fill_q == FILL_FULL) ? FILL_FULL : fill_q + FILL_W'(1);
	end

	assign hit = (fill_nx == FILL_FULL) && (win_nx[0] == HEADER_BYTE)
		&& (win_nx[1] == HEADER_BYTE) && (sum_nx == rx_byte);

	assign frame.gyro_x        = {win_nx[4], win_nx[5]};
	assign frame.gyro_y        = {win_nx[6], win_nx[7]};
	assign frame.gyro_z        = {win_nx[8], win_nx[9]};
	assign frame.yaw_angle     = {win_nx[10], win_nx[11]};
	assign frame.roll_angle    = {win_nx[12], win_nx[13]};
	assign frame.pitch_angle   = {win_nx[14], win_nx[15]};
	assign frame.device_status = win_nx[16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				win_q[i] <= '0;
			end
			sum_q  <= '0;
			fill_q <= '0;
		end else if (step) begin
			if (hit) begin
				// Drop the whole window once a frame is taken.
				for (int i = 0; i < FRAME_BYTES; i++) begin
					win_q[i] <= '0;
				end
				sum_q  <= '0;
				fill_q <= '0;
			end else begin
				win_q  <= win_nx;
				sum_q  <= sum_nx;
				fill_q <= fill_nx;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/imufp_unwrap.sv
`default_nettype none
module imufp_unwrap
	import imufp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [15:0]  yaw_angle,
	input  wire logic [15:0]  wrap_threshold,
	output imufp_track_t      track
);
	logic [15:0]        prev_yaw_q;
	logic signed [15:0] turns_q;
	logic signed [15:0] turns_nx;
	logic signed [31:0] offset_q;
	logic signed [31:0] offset_nx;
	logic [31:0]        count_q;
	logic signed [17:0] diff;
	logic signed [17:0] thr;
	logic               up;
	logic               dn;

	// A large backward jump means the yaw crossed zero going up, and the reverse.
	always_comb begin
		diff = $signed({2'b00, yaw_angle}) - $signed({2'b00, prev_yaw_q});
		thr  = $signed({2'b00, wrap_threshold});
		up   = (diff + thr) < 18'sd0;
		dn   = (diff - thr) > 18'sd0;
		turns_nx  = turns_q;
		offset_nx = offset_q;
		if (up && (turns_q != TURN_MAX)) begin
			turns_nx  = turns_q + 16'sd1;
			offset_nx = offset_q + TURN_HUNDREDTHS;
		end else if (dn && (turns_q != TURN_MIN)) begin
			turns_nx  = turns_q - 16'sd1;
			offset_nx = offset_q - TURN_HUNDREDTHS;
		end
	end

	assign track.turns        = turns_nx;
	assign track.total_yaw    = $signed({16'h0000, yaw_angle}) + offset_nx;
	assign track.frame_number = count_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_yaw_q <= '0;
			turns_q    <= '0;
			offset_q   <= '0;
			count_q    <= '0;
		end else if (step) begin
			prev_yaw_q <= yaw_angle;
			turns_q    <= turns_nx;
			offset_q   <= offset_nx;
			count_q    <= count_q + 32'd1;
		end
	end
endmodule
`default_nettype wire

// File: rtl/imu_frame_parser_yaw_unwrap.sv
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata = rx_byte
// m_axis    out  184    tdata = gyro_x, gyro_y, gyro_z, yaw_angle, roll_angle,
//                       pitch_angle, device_status, turns, total_yaw, frame_number
// cfg       in   16     cfg_wr_data = wrap_threshold, written when cfg_wr_en is high
//
// One byte is taken every cycle unless the input stalls. Each byte is held in the
// input register, where the window update, header and checksum match and turn
// tracking run; a matched frame is then loaded into the result register, whose
// valid flag drives m_axis_tvalid. The only stall is a matched frame meeting
// a full result register: that byte holds in the input register until the
// result transaction completes. Reset (arst_n low) empties both registers,
// the window and the yaw tracker.
`default_nettype none
module imu_frame_parser_yaw_unwrap
	import imufp_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] yaw_angle,
	// [79:64] roll_angle, [95:80] pitch_angle, [103:96] device_status,
	// [119:104] turns, [151:120] total_yaw, [183:152] frame_number
	output logic [OUT_BITS-1:0]      m_axis_tdata,
	input  wire logic                cfg_wr_en,
	input  wire logic [15:0]         cfg_wr_data     // wrap_threshold
);
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               out_valid_s2;
	logic [OUT_BITS-1:0] out_data_s2;
	logic [15:0]        wrap_threshold_q;

	imufp_frame_t       frame;
	imufp_track_t       track;
	logic               hit;
	logic               out_free;
	logic               adv_s1;

	// Result slot is free when empty or being drained this cycle.
	assign out_free = !out_valid_s2 || m_axis_tready;
	// A byte that matches no frame never needs the result slot.
	assign adv_s1   = valid_s1 && (!hit || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_threshold_q <= WRAP_THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			wrap_threshold_q <= cfg_wr_data;
		end
	end

	// Input register: capture each byte transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	imufp_window #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_byte(byte_s1),
		.step   (adv_s1),
		.frame  (frame),
		.hit    (hit)
	);

	imufp_unwrap u_unwrap (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv_s1 && hit),
		.yaw_angle     (frame.yaw_angle),
		.wrap_threshold(wrap_threshold_q),
		.track         (track)
	);

	// Result register: load on a matched frame, clear once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s1 && hit) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && hit) begin
			out_data_s2 <= {track.frame_number, track.total_yaw, track.turns,
				frame.device_status, frame.pitch_angle, frame.roll_angle,
				frame.yaw_angle, frame.gyro_z, frame.gyro_y, frame.gyro_x};
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = out_data_s2;
endmodule
`default_nettype wire

// File: rtl/imufp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module imufp_checker
	import imufp_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tready,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [OUT_BITS-1:0] m_axis_tdata
);
	logic               seen_q;
	logic [31:0]        last_frame_q;
	logic signed [47:0] total_exp;
	logic               out_take;
	logic               out_stall;
	logic               frame_next_ok;
	logic               total_ok;

	assign out_take  = m_axis_tvalid && m_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign total_exp = $signed({32'h0, m_axis_tdata[63:48]})
		+ $signed({{32{m_axis_tdata[119]}}, m_axis_tdata[119:104]}) * 48'sd36000;
	assign frame_next_ok = m_axis_tdata[183:152] == last_frame_q + 32'd1;
	assign total_ok      = m_axis_tdata[151:120] == total_exp[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_frame_q <= '0;
		end else if (out_take) begin
			seen_q       <= 1'b1;
			last_frame_q <= m_axis_tdata[183:152];
		end
	end

	`ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |-> !m_axis_tvalid, "result valid during reset")
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_stall |=> m_axis_tvalid, "result dropped while stalled")
	`ASSERT_CLK(a_frame_seq, clk, arst_n, out_take && seen_q |-> frame_next_ok, "frame number skipped")
	`ASSERT_CLK(a_total_yaw, clk, arst_n, m_axis_tvalid |-> total_ok, "total yaw mismatch")
	`ASSERT_CLK(a_ready_free, clk, arst_n, !s_axis_tready |-> m_axis_tvalid, "input stalled, result empty")
endmodule

bind imu_frame_parser_yaw_unwrap imufp_checker u_imufp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none
module testbench;
	import imufp_pkg::*;

	localparam int FRAME_LEN    = FRAME_BYTES_DEF;
	localparam int MAX_REPORTS  = 10;
	localparam int TARGET_BYTES = 1450;  // stop the random stream near this byte count
	localparam int CALM_BYTES   = 220;   // final stretch sent with no idling on either side
	localparam int HOLD_CYCLES  = 400;   // long sink hold-off used to back the block up

	// Ways a built frame can be spoiled on purpose.
	typedef enum int {
		FRAME_OK,
		FRAME_BAD_SYNC0,
		FRAME_BAD_SYNC1,
		FRAME_BAD_SUM
	} frame_fault_e;

	// Result layout matching m_axis_tdata: the last member sits in the lowest bits.
	typedef struct packed {
		logic [31:0]        frame_number;
		logic signed [31:0] total_yaw;
		logic signed [15:0] turns;
		logic [7:0]         device_status;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic [15:0]        yaw_angle;
		logic signed [15:0] gyro_z;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_x;
	} imu_result_t;

	logic                clk           = 1'b0;
	logic                arst_n;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata  = 8'h00;   // [7:0] rx_byte
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] yaw_angle,
	// [79:64] roll_angle, [95:80] pitch_angle, [103:96] device_status,
	// [119:104] turns, [151:120] total_yaw, [183:152] frame_number
	logic [OUT_BITS-1:0] m_axis_tdata;
	logic                cfg_wr_en     = 1'b0;
	logic [15:0]         cfg_wr_data   = 16'h0000;   // wrap_threshold

	// Shadow copy of the parser: sliding byte window, yaw tracker, threshold.
	logic [7:0]         win_bytes [FRAME_LEN] = '{default: 8'h00};
	int                 win_fill    = 0;
	logic [15:0]        last_yaw    = 16'h0000;
	logic signed [15:0] turn_count  = 16'sh0000;
	logic [31:0]        frame_count = 32'h0;
	logic [15:0]        wrap_thr    = WRAP_THRESHOLD_RST;

	imu_result_t pending_results [$];   // decoded frames still owed by the block
	int          mismatches = 0;
	int          bytes_sent = 0;
	bit          idle_on    = 1'b1;     // random gaps on both sides while set
	bit          hold_req   = 1'b0;     // ask the sink for one long hold-off

	imu_frame_parser_yaw_unwrap #(
		.FRAME_BYTES(FRAME_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Shift one byte into the shadow window and decode a frame if the window holds one.
	// Returns 1 with the decoded fields when a frame matches.
	function automatic bit predict_frame(input logic [7:0] rx, output imu_result_t r);
		logic [7:0] sum;
		int         yaw_step;
		int         thr;
		longint     total;
		r = '0;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			win_bytes[i] = win_bytes[i + 1];
		win_bytes[FRAME_LEN - 1] = rx;
		if (win_fill < FRAME_LEN)
			win_fill++;
		// A window that is not yet full never matches.
		if (win_fill < FRAME_LEN)
			return 1'b0;
		if (win_bytes[0] != HEADER_BYTE || win_bytes[1] != HEADER_BYTE)
			return 1'b0;
		sum = 8'h00;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum += win_bytes[i];
		if (sum != win_bytes[FRAME_LEN - 1])
			return 1'b0;

		r.gyro_x        = {win_bytes[4], win_bytes[5]};
		r.gyro_y        = {win_bytes[6], win_bytes[7]};
		r.gyro_z        = {win_bytes[8], win_bytes[9]};
		r.yaw_angle     = {win_bytes[10], win_bytes[11]};
		r.roll_angle    = {win_bytes[12], win_bytes[13]};
		r.pitch_angle   = {win_bytes[14], win_bytes[15]};
		r.device_status = win_bytes[16];

		// Big drop in yaw means one turn forward, big rise one turn back; saturate.
		yaw_step = int'(r.yaw_angle) - int'(last_yaw);
		thr      = int'(wrap_thr);
		if (yaw_step < -thr && turn_count < TURN_MAX)
			turn_count = turn_count + 16'sd1;
		if (-yaw_step < -thr && turn_count > TURN_MIN)
			turn_count = turn_count - 16'sd1;
		last_yaw    = r.yaw_angle;
		frame_count = frame_count + 32'd1;

		total          = longint'(r.yaw_angle) + 64'sd36000 * longint'(turn_count);
		r.turns        = turn_count;
		r.total_yaw    = total[31:0];
		r.frame_number = frame_count;

		// Start over with an empty window after every matched frame.
		win_bytes = '{default: 8'h00};
		win_fill  = 0;
		return 1'b1;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch in %s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	// Match one result transaction against the oldest owed frame.
	function automatic void check_result(input imu_result_t got);
		imu_result_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("result with no frame owed: %h", got);
			return;
		end
		want = pending_results.pop_front();
		compare_field("gyro_x", 32'(want.gyro_x), 32'(got.gyro_x));
		compare_field("gyro_y", 32'(want.gyro_y), 32'(got.gyro_y));
		compare_field("gyro_z", 32'(want.gyro_z), 32'(got.gyro_z));
		compare_field("yaw_angle", 32'(want.yaw_angle), 32'(got.yaw_angle));
		compare_field("roll_angle", 32'(want.roll_angle), 32'(got.roll_angle));
		compare_field("pitch_angle", 32'(want.pitch_angle), 32'(got.pitch_angle));
		compare_field("device_status", 32'(want.device_status), 32'(got.device_status));
		compare_field("turns", 32'(want.turns), 32'(got.turns));
		compare_field("total_yaw", want.total_yaw, got.total_yaw);
		compare_field("frame_number", want.frame_number, got.frame_number);
	endfunction

	// Sink side: check every result transaction, then pick tready for the next cycle.
	// Values read right after the edge are the ones the edge sampled, since all
	// drivers here and in the block update in the nonblocking region.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				check_result(imu_result_t'(m_axis_tdata));
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// Hold off for a long stretch so the result register fills and input stalls.
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one byte, maybe after a random gap, and hold it until the transaction completes.
	// tvalid is left high afterwards so back-to-back bytes never lower and raise it in one step.
	task automatic send_byte(input logic [7:0] rx);
		imu_result_t r;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rx;
		do
			@(posedge clk);
		while (!s_axis_tready);
		bytes_sent++;
		if (predict_frame(rx, r))
			pending_results.push_back(r);
	endtask

	// Drop tvalid, wait until every owed frame is out, then let in-flight bytes settle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the threshold only with the block idle.
	task automatic write_threshold(input logic [15:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		wrap_thr = value;
	endtask

	// Build one frame: two sync bytes, two spare bytes, big-endian words, status, sum.
	task automatic send_frame(input logic [15:0] gx, input logic [15:0] gy,
			input logic [15:0] gz, input logic [15:0] yaw, input logic [15:0] roll,
			input logic [15:0] pitch, input logic [7:0] status, input frame_fault_e fault);
		logic [7:0] fb [FRAME_LEN];
		logic [7:0] sum;
		fb[0]  = HEADER_BYTE;
		fb[1]  = HEADER_BYTE;
		fb[2]  = 8'($urandom);
		fb[3]  = 8'($urandom);
		{fb[4], fb[5]}   = gx;
		{fb[6], fb[7]}   = gy;
		{fb[8], fb[9]}   = gz;
		{fb[10], fb[11]} = yaw;
		{fb[12], fb[13]} = roll;
		{fb[14], fb[15]} = pitch;
		fb[16] = status;
		sum = 8'h00;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum += fb[i];
		fb[FRAME_LEN - 1] = sum;
		case (fault)
			FRAME_BAD_SYNC0: fb[0] ^= 8'(1 << $urandom_range(0, 7));
			FRAME_BAD_SYNC1: fb[1] ^= 8'(1 << $urandom_range(0, 7));
			FRAME_BAD_SUM:   fb[FRAME_LEN - 1] += 8'($urandom_range(1, 255));
			default: ;
		endcase
		foreach (fb[i])
			send_byte(fb[i]);
	endtask

	// Random word leaning on the signed and unsigned extremes.
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Yaw random, extreme, or from the tracked one: small steps, wrap jumps, near-threshold ones.
	function automatic logic [15:0] pick_yaw();
		logic [15:0] delta;
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return last_yaw + 16'($urandom_range(0, 1000)) - 16'd500;
			2: begin
				if (last_yaw < 16'd32768)
					return 16'hFFFF - 16'($urandom_range(0, 3000));
				else
					return 16'($urandom_range(0, 3000));
			end
			3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: begin
				delta = wrap_thr + 16'($urandom_range(0, 2)) - 16'd1;
				if ($urandom_range(0, 1))
					return last_yaw - delta;
				else
					return last_yaw + delta;
			end
		endcase
	endfunction

	function automatic logic [15:0] pick_threshold();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd36000;
			2: return 16'hFFFF;
			3: return WRAP_THRESHOLD_RST;
			4: return 16'($urandom);
			default: return 16'($urandom_range(0, 36000));
		endcase
	endfunction

	task automatic send_random_frame(input frame_fault_e fault);
		send_frame(pick_word(), pick_word(), pick_word(), pick_yaw(), pick_word(),
			pick_word(), 8'($urandom), fault);
	endtask

	// Bytes arriving before the window is full, then the first frame, whose yaw is
	// compared against a tracked yaw of zero.
	task automatic test_partial_window();
		repeat (11) send_byte(8'($urandom));
		send_frame(16'h1234, 16'hFEDC, 16'h0001, 16'hFFFF, 16'h8001, 16'h7FFE, 8'hA5,
			FRAME_OK);
	endtask

	task automatic test_field_extremes();
		send_frame(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 8'h00,
			FRAME_OK);
		send_frame(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF,
			FRAME_OK);
	endtask

	// Broken sync bytes and a bad sum slide the window; a clean frame must still land.
	task automatic test_bad_frames();
		send_random_frame(FRAME_BAD_SYNC0);
		send_random_frame(FRAME_BAD_SYNC1);
		send_random_frame(FRAME_BAD_SUM);
		repeat (3) send_byte(HEADER_BYTE);
		send_random_frame(FRAME_OK);
	endtask

	// Walk the threshold through its extremes, one above its range included.
	task automatic test_thresholds();
		logic [15:0] levels [6] = '{16'd0, 16'd36000, 16'hFFFF, 16'd1, 16'($urandom),
			WRAP_THRESHOLD_RST};
		foreach (levels[i]) begin
			write_threshold(levels[i]);
			repeat (4) send_random_frame(FRAME_OK);
		end
		wait_idle();
	endtask

	// Frames sent back to back while the sink holds off: the block must stall its input.
	task automatic test_back_pressure();
		idle_on  = 1'b0;
		hold_req = 1'b1;
		repeat (10) send_random_frame(FRAME_OK);
		idle_on = 1'b1;
		wait_idle();
	endtask

	// Mostly clean frames with random content, some spoiled frames and noise bursts;
	// the threshold changes between phases. Turn saturation is not reached: it would
	// take tens of thousands of frames.
	task automatic test_random_stream();
		int kind;
		int frames_since_cfg;
		frames_since_cfg = 0;
		while (bytes_sent < TARGET_BYTES) begin
			if (bytes_sent >= TARGET_BYTES - CALM_BYTES)
				idle_on = 1'b0;
			if (frames_since_cfg >= 15) begin
				write_threshold(pick_threshold());
				frames_since_cfg = 0;
			end
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				send_random_frame(FRAME_OK);
				frames_since_cfg++;
			end else if (kind < 17) begin
				send_random_frame(frame_fault_e'($urandom_range(1, 3)));
			end else begin
				repeat ($urandom_range(1, 12))
					send_byte($urandom_range(0, 2) == 0 ? HEADER_BYTE : 8'($urandom));
			end
		end
	endtask

	initial begin
		// Assert reset through the nonblocking region so the block sees a falling edge.
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_partial_window();
		test_field_extremes();
		test_bad_frames();
		test_thresholds();
		test_back_pressure();
		test_random_stream();

		idle_on = 1'b0;
		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
